// ===== hdl/fifo_with_occupancy_statistics_top_defines.svh =====
// Assertion macros for the FIFO with occupancy statistics.
// No dependencies; included by the modules that carry assertions.
`ifndef FIFO_WITH_OCCUPANCY_STATISTICS_TOP_DEFINES_SVH
`define FIFO_WITH_OCCUPANCY_STATISTICS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FOS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FOS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/fos_pkg.sv =====
// Shared types, constants and helpers for the FIFO with occupancy statistics.
// No dependencies.
package fos_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = 8;
    localparam int CAP_W      = 9;
    localparam int TIME_W     = 32;
    localparam int AREA_W     = 64;
    localparam int PROD_W     = TIME_W + CNT_W;
    localparam int STATUS_W   = 2;
    localparam int IN_TDATA_W  = DATA_W + TIME_W;
    localparam int OUT_TDATA_W = DATA_W + 2 * CNT_W + AREA_W + TIME_W;
    localparam int CAP_RESET  = 256;
    localparam int CAP_MIN    = 2;
    localparam int CAP_MAX    = (DEPTH < 256) ? DEPTH : 256;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_ACC
    } fos_state_t;

    typedef struct packed {
        logic diff_en;
        logic mul_en;
        logic acc_en;
    } fos_ctrl_t;

    // Most entries held for a given capacity register value.
    function automatic logic [CNT_W-1:0] held_limit(input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] c;
        begin
            c = cap;
            if (c < CAP_W'(CAP_MIN))
            begin
                c = CAP_W'(CAP_MIN);
            end
            if (c > CAP_W'(CAP_MAX))
            begin
                c = CAP_W'(CAP_MAX);
            end
            held_limit = CNT_W'(c - CAP_W'(1));
        end
    endfunction

endpackage

// ===== hdl/fos_stats.sv =====
// Time-weighted occupancy accumulator: elapsed time, multiply, saturating sums.
// Depends on fos_pkg.
module fos_stats (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fos_pkg::fos_ctrl_t         ctrl,
    input  logic [fos_pkg::TIME_W-1:0] event_time,
    input  logic [fos_pkg::CNT_W-1:0]  count,
    output logic [fos_pkg::AREA_W-1:0] area_sum,
    output logic [fos_pkg::TIME_W-1:0] time_sum
);
    import fos_pkg::*;

    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [PROD_W-1:0] product_reg;
    logic [AREA_W-1:0] weighted_reg;
    logic [TIME_W-1:0] total_reg;
    logic [AREA_W:0]   weighted_sum;
    logic [TIME_W:0]   total_sum;
    logic              forward;

    assign forward      = event_time >= last_time_reg;
    assign weighted_sum = {1'b0, weighted_reg} + {{(AREA_W + 1 - PROD_W){1'b0}}, product_reg};
    assign total_sum    = {1'b0, total_reg} + {1'b0, elapsed_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            weighted_reg  <= '0;
            total_reg     <= '0;
        end
        else
        begin
            if (ctrl.diff_en && forward)
            begin
                last_time_reg <= event_time;
            end
            if (ctrl.acc_en)
            begin
                weighted_reg <= weighted_sum[AREA_W] ? '1 : weighted_sum[AREA_W-1:0];
                total_reg    <= total_sum[TIME_W] ? '1 : total_sum[TIME_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.diff_en)
        begin
            elapsed_reg <= forward ? (event_time - last_time_reg) : '0;
        end
        if (ctrl.mul_en)
        begin
            product_reg <= PROD_W'(elapsed_reg) * PROD_W'(count);
        end
    end

    assign area_sum = weighted_reg;
    assign time_sum = total_reg;

endmodule

// ===== hdl/fifo_with_occupancy_statistics_top.sv =====
// Circular FIFO with time-weighted occupancy statistics, top level.
// Depends on fos_pkg, fos_stats and fifo_with_occupancy_statistics_top_defines.svh.
//
// Usage:
//   s_axis carries requests: tuser selects enqueue (0) or dequeue (1), tdata holds
//   the payload and the event time. Every request yields one word on m_axis: a
//   status in tuser and, in tdata, the dequeued payload, the occupancy, the peak
//   occupancy and the area and time sums after the request.
//   cfg writes the capacity register; cfg_ready is always high. Write it only
//   while no request is in flight.
//   Each request passes through the steps accept, elapsed-time subtract,
//   elapsed x occupancy multiply, and accumulate and queue update; the result
//   is registered in the accumulate step, which waits while m_axis stalls. One
//   request is worked on at a time; the payload store is a 256 x 32 single-port
//   RAM with a registered read issued at accept.
//   Reset clears pointers, counts and sums and sets capacity to 256; the payload
//   store is not cleared, and only written entries ever reach m_axis.
//   If m_axis stalls, the result is held and the next request is accepted, but
//   it waits in the accumulate step until the held result is taken.
`include "fifo_with_occupancy_statistics_top_defines.svh"
module fifo_with_occupancy_statistics_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] entry_data, [63:32] event_time
    input  logic [fos_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] data_out, [39:32] occupancy, [47:40] max_occupancy,
    // [111:48] area_sum, [143:112] time_sum
    output logic [fos_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [fos_pkg::STATUS_W-1:0]    m_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fos_pkg::CAP_W-1:0]       cfg_data
);
    import fos_pkg::*;

    fos_state_t          state_reg, state_next;
    fos_ctrl_t           ctrl;
    logic                out_free;
    logic                accept;

    logic                req_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [TIME_W-1:0]   time_reg;

    logic [DATA_W-1:0]   mem [DEPTH];
    logic [DATA_W-1:0]   rdata_reg;

    logic [IDX_W-1:0]    rd_idx_reg, wr_idx_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    peak_reg;
    logic [CAP_W-1:0]    cap_reg;

    logic                full, empty, do_enq, do_deq;
    logic [STATUS_W-1:0] status_next, status_reg;
    logic [DATA_W-1:0]   dout_reg;
    logic                out_valid_reg;

    logic [AREA_W-1:0]   area_sum;
    logic [TIME_W-1:0]   time_sum;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        ctrl          = '0;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_DIFF: ctrl.diff_en = 1'b1;
            ST_MUL:  ctrl.mul_en = 1'b1;
            ST_ACC:  ctrl.acc_en = out_free;
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= s_axis_tuser[0];
            data_reg <= s_axis_tdata[DATA_W-1:0];
            time_reg <= s_axis_tdata[DATA_W +: TIME_W];
        end
    end

    // payload store: read issued at accept, written at commit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= mem[rd_idx_reg];
        end
        if (ctrl.acc_en && do_enq)
        begin
            mem[wr_idx_reg] <= data_reg;
        end
    end

    assign full   = count_reg >= held_limit(cap_reg);
    assign empty  = count_reg == '0;
    assign do_enq = (req_reg == REQ_ENQ) && !full;
    assign do_deq = (req_reg == REQ_DEQ) && !empty;

    always_comb
    begin
        count_next  = count_reg;
        status_next = STATUS_OK;
        if (req_reg == REQ_ENQ)
        begin
            if (full)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            cap_reg       <= CAP_W'(CAP_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (ctrl.acc_en)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
                if (do_enq)
                begin
                    wr_idx_reg <= wr_idx_reg + IDX_W'(1);
                end
                if (do_deq)
                begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                end
                if (count_next > peak_reg)
                begin
                    peak_reg <= count_next;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en)
        begin
            status_reg <= status_next;
            dout_reg   <= do_deq ? rdata_reg : '0;
        end
    end

    fos_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .event_time (time_reg),
        .count      (count_reg),
        .area_sum   (area_sum),
        .time_sum   (time_sum)
    );

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {time_sum, area_sum, peak_reg, count_reg, dout_reg};

    `FOS_ASSERT_IMPLIES(a_count_matches_ptrs, clk, rst_n, 1'b1,
        IDX_W'(wr_idx_reg - rd_idx_reg) == IDX_W'(count_reg))
    `FOS_ASSERT_IMPLIES(a_occ_le_peak, clk, rst_n, m_axis_tvalid, count_reg <= peak_reg)
    `FOS_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_reg == ST_DIFF)
    `FOS_ASSERT_NEXT(a_deq_drops_count, clk, rst_n, ctrl.acc_en && do_deq,
        count_reg == $past(count_reg) - CNT_W'(1))
    `FOS_ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        !ctrl.acc_en)

endmodule
